// ===== hw/rtl/crpp_pkg.sv =====
// ----------------------------------------------------------------------------
// crpp_pkg
// Shared types, register codes and reduction functions for the colour
// reduce, pack and packetise block.
// ----------------------------------------------------------------------------
package crpp_pkg;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_DEPTH         = 2'd0;
  localparam logic [1:0] REG_HDR_TYPE      = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_SIZE  = 2'd2;
  localparam logic [1:0] REG_PACKET_COUNT  = 2'd3;

  localparam logic [3:0] DEPTH_3BIT = 4'd3;
  localparam logic [3:0] DEPTH_4BIT = 4'd4;

  // one payload byte plus what the back end needs to frame it
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;        // first byte of a packet: send header first
    logic [7:0] pkt_idx;
    logic       pkt_end;
    logic       frm_end;
  } job_t;

  // output sequencing
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_INDEX = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  // 8 bit component down to 3 bits: (c*225 + 4096) >> 13
  function automatic logic [3:0] reduce3(input logic [7:0] c);
    logic [15:0] p;
    p = 16'(c) * 16'd225 + 16'd4096;
    return {1'b0, p[15:13]};
  endfunction

  // 8 bit component down to 4 bits: (c*15 + 135) >> 8
  function automatic logic [3:0] reduce4(input logic [7:0] c);
    logic [11:0] p;
    p = 12'(c) * 12'd15 + 12'd135;
    return p[11:8];
  endfunction

endpackage

// ===== hw/rtl/crpp_front.sv =====
// ----------------------------------------------------------------------------
// crpp_front
// Accepts components, at depth 3 or 4 reduces and pairs them into bytes, and
// keeps the packet position; pushes one job per payload byte into the queue.
// ----------------------------------------------------------------------------
module crpp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_component,
  input  logic          in_last,
  input  logic          q_full,
  input  logic [3:0]    comp_depth,
  input  logic [15:0]   payload_size,
  input  logic [7:0]    packet_count,
  output logic          in_ready,
  output logic          q_push,
  output crpp_pkg::job_t q_job
);
  import crpp_pkg::*;

  logic [3:0]  held_nibble_r, held_nibble_nxt;
  logic        high_phase_r,  high_phase_nxt;
  logic [15:0] byte_in_pkt_r, byte_in_pkt_nxt;
  logic [7:0]  pkt_idx_r,     pkt_idx_nxt;

  logic        accept;
  logic        pack_mode;
  logic [3:0]  red;
  logic        emit;
  logic [7:0]  pay_byte;
  logic [15:0] psize;
  logic [7:0]  pcount;
  logic [16:0] next_cnt;
  logic        pkt_full;
  logic        send;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  assign pack_mode = (comp_depth == DEPTH_3BIT) || (comp_depth == DEPTH_4BIT);
  assign red       = (comp_depth == DEPTH_3BIT) ? reduce3(in_component)
                                                : reduce4(in_component);

  assign psize    = (payload_size == 16'd0) ? 16'd1 : payload_size;
  assign pcount   = (packet_count == 8'd0) ? 8'd1 : packet_count;
  assign next_cnt = {1'b0, byte_in_pkt_r} + 17'd1;
  assign pkt_full = next_cnt >= {1'b0, psize};

  always_comb begin
    emit     = 1'b1;
    pay_byte = in_component;
    if (pack_mode) begin
      if (high_phase_r) begin
        emit     = in_last;
        pay_byte = {red, 4'd0};
      end else begin
        pay_byte = {held_nibble_r, red};
      end
    end
  end

  // drop payload once the frame's packets are all used
  assign send = emit && (pkt_idx_r < pcount);

  assign q_push          = accept && send;
  assign q_job.data      = pay_byte;
  assign q_job.hdr       = (byte_in_pkt_r == 16'd0);
  assign q_job.pkt_idx   = pkt_idx_r;
  assign q_job.pkt_end   = pkt_full || in_last;
  assign q_job.frm_end   = in_last;

  always_comb begin
    held_nibble_nxt = held_nibble_r;
    high_phase_nxt  = high_phase_r;
    byte_in_pkt_nxt = byte_in_pkt_r;
    pkt_idx_nxt     = pkt_idx_r;
    if (accept) begin
      if (pack_mode) begin
        if (high_phase_r && !in_last) begin
          held_nibble_nxt = red;
          high_phase_nxt  = 1'b0;
        end else begin
          held_nibble_nxt = 4'd0;
          high_phase_nxt  = 1'b1;
        end
      end
      if (send) begin
        if (pkt_full) begin
          byte_in_pkt_nxt = 16'd0;
          pkt_idx_nxt     = pkt_idx_r + 8'd1;
        end else begin
          byte_in_pkt_nxt = next_cnt[15:0];
        end
      end
      if (in_last) begin
        held_nibble_nxt = 4'd0;
        high_phase_nxt  = 1'b1;
        byte_in_pkt_nxt = 16'd0;
        pkt_idx_nxt     = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_nibble_r <= 4'd0;
      high_phase_r  <= 1'b1;
      byte_in_pkt_r <= 16'd0;
      pkt_idx_r     <= 8'd0;
    end else begin
      held_nibble_r <= held_nibble_nxt;
      high_phase_r  <= high_phase_nxt;
      byte_in_pkt_r <= byte_in_pkt_nxt;
      pkt_idx_r     <= pkt_idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/crpp_fifo.sv =====
// ----------------------------------------------------------------------------
// crpp_fifo
// Small register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module crpp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crpp_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output crpp_pkg::job_t head
);
  import crpp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/crpp_back.sv =====
// ----------------------------------------------------------------------------
// crpp_back
// Expands each job into header and payload transfers and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module crpp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  crpp_pkg::job_t q_head,
  input  logic [7:0]     hdr_type,
  input  logic           out_ready,
  output logic           q_pop,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           out_pkt_end,
  output logic           out_frm_end,
  output logic           out_run_last
);
  import crpp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r,  byte_nxt;
  logic       pend_r,  pend_nxt;
  logic       fend_r,  fend_nxt;
  logic       rlast_r, rlast_nxt;
  logic       load;

  // refill the output register when it is empty or being taken
  assign load = !valid_r || out_ready;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    pend_nxt  = pend_r;
    fend_nxt  = fend_r;
    rlast_nxt = rlast_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        byte_nxt  = q_head.data;
        pend_nxt  = q_head.pkt_end;
        fend_nxt  = q_head.frm_end;
        rlast_nxt = 1'b1;
        case (phase_r)
          PH_FIRST: begin
            if (q_head.hdr) begin
              byte_nxt  = hdr_type;
              pend_nxt  = 1'b0;
              fend_nxt  = 1'b0;
              rlast_nxt = 1'b0;
              phase_nxt = PH_INDEX;
            end else begin
              q_pop = 1'b1;
            end
          end
          PH_INDEX: begin
            byte_nxt  = q_head.pkt_idx;
            pend_nxt  = 1'b0;
            fend_nxt  = 1'b0;
            rlast_nxt = 1'b0;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            q_pop     = 1'b1;
            phase_nxt = PH_FIRST;
          end
          default: begin
            valid_nxt = 1'b0;
            phase_nxt = PH_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    pend_r  <= pend_nxt;
    fend_r  <= fend_nxt;
    rlast_r <= rlast_nxt;
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_pkt_end  = pend_r;
  assign out_frm_end  = fend_r;
  assign out_run_last = rlast_r;

endmodule

// ===== hw/rtl/color_reduce_pack_packetizer.sv =====
// ----------------------------------------------------------------------------
// color_reduce_pack_packetizer
// Path: with the queue empty, a payload byte is pushed when its component is
//   accepted and then registered on out_ from the queue head; at a packet
//   start its two header transfers come first, and a queue backlog delays it.
// Throughput: one component per cycle on in_ unless the queue is full, one
//   transfer per cycle on out_ while out_tready is high; each packet start
//   adds two header transfers on out_, which the queue covers only briefly:
//   once it fills, in_ stalls for them. Reset (rst_n, synchronous): queue and
//   packet position cleared, registers back to depth 8, header type 0,
//   payload size 1, packet count 1.
module color_reduce_pack_packetizer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] component
  input  logic        in_tlast,   // frame_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // frame_end
  output logic [1:0]  out_tuser,  // [0] packet_end, [1] run_last
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import crpp_pkg::*;

  logic [3:0]  comp_depth_r;
  logic [7:0]  hdr_type_r;
  logic [15:0] payload_size_r;
  logic [7:0]  packet_count_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  logic        q_push, q_pop, q_full, q_empty;
  job_t        q_job, q_head;
  logic        pkt_end, run_last;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_depth_r    <= 4'd8;
      hdr_type_r      <= 8'd0;
      payload_size_r  <= 16'd1;
      packet_count_r  <= 8'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEPTH:         comp_depth_r    <= cfg_pwdata[3:0];
        REG_HDR_TYPE:      hdr_type_r      <= cfg_pwdata[7:0];
        REG_PAYLOAD_SIZE:  payload_size_r  <= cfg_pwdata[15:0];
        REG_PACKET_COUNT:  packet_count_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEPTH:         cfg_prdata = {28'd0, comp_depth_r};
      REG_HDR_TYPE:      cfg_prdata = {24'd0, hdr_type_r};
      REG_PAYLOAD_SIZE:  cfg_prdata = {16'd0, payload_size_r};
      REG_PACKET_COUNT:  cfg_prdata = {24'd0, packet_count_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  crpp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_component (in_tdata),
    .in_last      (in_tlast),
    .q_full       (q_full),
    .comp_depth   (comp_depth_r),
    .payload_size (payload_size_r),
    .packet_count (packet_count_r),
    .in_ready     (in_tready),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  crpp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  crpp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .hdr_type      (hdr_type_r),
    .out_ready     (out_tready),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_byte      (out_tdata),
    .out_pkt_end   (pkt_end),
    .out_frm_end   (out_tlast),
    .out_run_last  (run_last)
  );

  assign out_tuser = {run_last, pkt_end};

endmodule
